// ===== design/spg_pkg.sv =====
// Package for the four-channel servo PWM generator: register codes, reset values, result type.
package spg_pkg;

  localparam int unsigned REG_W = 16;
  localparam int unsigned PWM_BITS = 4;
  localparam int unsigned MOTOR_W = 3;
  localparam int unsigned REG_IDX_W = 2;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_PRESCALE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN      = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAX      = 2'd3;

  // request types
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [REG_W-1:0] RESET_PRESCALE = 16'd99;
  localparam logic [REG_W-1:0] RESET_PERIOD   = 16'd19999;
  localparam logic [REG_W-1:0] RESET_MIN      = 16'd1000;
  localparam logic [REG_W-1:0] RESET_MAX      = 16'd2000;

  typedef struct packed {
    logic [PWM_BITS-1:0] pwm_out;
    logic [REG_W-1:0]    counter_value;
    logic                update_event;
    logic                write_rejected;
  } result_t;

endpackage

// ===== design/spg_if.sv =====
// Valid/ready channel interfaces for the request and result streams.
interface spg_in_if import spg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [MOTOR_W-1:0] motor;
  logic [REG_W-1:0]   req_width;

  modport source (output valid, output req_type, output motor, output req_width,
                  input ready);
  modport sink   (input valid, input req_type, input motor, input req_width,
                  output ready);
endinterface

interface spg_out_if import spg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PWM_BITS-1:0] pwm_out;
  logic [REG_W-1:0]    counter_value;
  logic                update_event;
  logic                write_rejected;

  modport source (output valid, output pwm_out, output counter_value,
                  output update_event, output write_rejected, input ready);
  modport sink   (input valid, input pwm_out, input counter_value,
                  input update_event, input write_rejected, output ready);
endinterface

// ===== design/servo_pwm_generator_4ch_top.sv =====
// Edge-aligned PWM timer with preloaded compares: top level.
// Latency: a result is valid in the cycle after its request beat is accepted.
// Throughput: one item per cycle; the request side stalls only while a result
// sits in the output register and the result side is not ready.
// Reset (rst, synchronous, active high) restores the register defaults, zeroes
// both counters, loads every compare with the default minimum and empties the output.
module servo_pwm_generator_4ch_top
  import spg_pkg::*;
#(
  parameter int unsigned CHANNELS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  spg_in_if.sink               in_ch,
  spg_out_if.source            out_ch
);

  logic [REG_W-1:0] prescale_minus_one;
  logic [REG_W-1:0] period_minus_one;
  logic [REG_W-1:0] min_pulse;
  logic [REG_W-1:0] max_pulse;

  logic [REG_W-1:0] prescale_count, prescale_count_next;
  logic [REG_W-1:0] period_count, period_count_next;
  logic [CHANNELS-1:0][REG_W-1:0] preload_compare, preload_compare_next;
  logic [CHANNELS-1:0][REG_W-1:0] active_compare, active_compare_next;

  result_t          result, result_next;
  logic             out_valid;

  logic             accept;
  logic             is_tick;
  logic             pre_wrap;
  logic             per_wrap;
  logic             update;
  logic [CHANNELS-1:0] hit;
  logic             rejected;
  logic [REG_W-1:0] clamped;
  logic [PWM_BITS-1:0] pwm_bits;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_tick     = (in_ch.req_type == REQ_TICK);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_minus_one <= RESET_PRESCALE;
      period_minus_one   <= RESET_PERIOD;
      min_pulse          <= RESET_MIN;
      max_pulse          <= RESET_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PRESCALE: prescale_minus_one <= cfg_data;
        REG_PERIOD:   period_minus_one   <= cfg_data;
        REG_MIN:      min_pulse          <= cfg_data;
        REG_MAX:      max_pulse          <= cfg_data;
        default:      ;
      endcase
    end
  end

  // clamp, min checked first
  always_comb begin
    if (in_ch.req_width < min_pulse) begin
      clamped = min_pulse;
    end else if (in_ch.req_width > max_pulse) begin
      clamped = max_pulse;
    end else begin
      clamped = in_ch.req_width;
    end
  end

  assign pre_wrap = (prescale_count >= prescale_minus_one);
  assign per_wrap = (period_count >= period_minus_one);
  assign update   = accept && is_tick && pre_wrap && per_wrap;

  always_comb begin
    for (int k = 0; k < CHANNELS; k++) begin
      hit[k] = accept && !is_tick
               && ({1'b0, in_ch.motor} == (MOTOR_W + 1)'(k + 1));
    end
  end
  assign rejected = !is_tick && (hit == '0);

  always_comb begin
    prescale_count_next = prescale_count;
    period_count_next   = period_count;
    if (accept && is_tick) begin
      if (pre_wrap) begin
        prescale_count_next = '0;
        period_count_next   = per_wrap ? '0 : period_count + 1'b1;
      end else begin
        prescale_count_next = prescale_count + 1'b1;
      end
    end
    for (int k = 0; k < CHANNELS; k++) begin
      preload_compare_next[k] = hit[k] ? clamped : preload_compare[k];
      active_compare_next[k]  = update ? preload_compare[k] : active_compare[k];
    end
  end

  // only the first four channels reach the output
  for (genvar k = 0; k < PWM_BITS; k++) begin : g_pwm
    if (k < CHANNELS) begin : g_on
      assign pwm_bits[k] = (period_count_next < active_compare_next[k]);
    end else begin : g_off
      assign pwm_bits[k] = 1'b0;
    end
  end

  always_comb begin
    result_next.pwm_out        = pwm_bits;
    result_next.counter_value  = period_count_next;
    result_next.update_event   = update;
    result_next.write_rejected = rejected;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count  <= '0;
      period_count    <= '0;
      preload_compare <= {CHANNELS{RESET_MIN}};
      active_compare  <= {CHANNELS{RESET_MIN}};
      out_valid       <= 1'b0;
    end else begin
      prescale_count  <= prescale_count_next;
      period_count    <= period_count_next;
      preload_compare <= preload_compare_next;
      active_compare  <= active_compare_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, held while stalled
  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

  assign out_ch.valid          = out_valid;
  assign out_ch.pwm_out        = result.pwm_out;
  assign out_ch.counter_value  = result.counter_value;
  assign out_ch.update_event   = result.update_event;
  assign out_ch.write_rejected = result.write_rejected;

  a_update_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && result.update_event |-> result.counter_value == '0)
    else $error("update event with nonzero counter");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(result.update_event && result.write_rejected))
    else $error("update event and rejected write in one result");

  a_write_hold: assert property (@(posedge clk) disable iff (rst)
    accept && !is_tick |=> $stable(period_count) && $stable(active_compare))
    else $error("write moved the counter or active compares");

  a_reject_hold: assert property (@(posedge clk) disable iff (rst)
    accept && rejected |=> $stable(preload_compare))
    else $error("rejected write changed a preload compare");

  a_counter_match: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.counter_value == period_count)
    else $error("result counter differs from state");

endmodule
